@@ sv/cga_pkg.sv @@
// Shared codes and field widths for the core group allocator.
`timescale 1ns / 1ps

package cga_pkg;

   // result status codes
   typedef enum logic [1:0] {
      ST_GRANT   = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_REFUSE  = 2'd2,
      ST_RELEASE = 2'd3
   } status_type;

   // request command codes
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // fixed field widths
   localparam int JOB_TAG_W  = 8;
   localparam int COUNT_W    = 5;
   localparam int SLOT_W     = 4;
   localparam int CORE_W     = 4;
   localparam int RELEASED_W = 5;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

endpackage

@@ sv/cga_owner_ram.sv @@
// Owner tag store: one write port, one registered read port.
`timescale 1ns / 1ps

module cga_owner_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/core_group_allocator.sv @@
// Core group allocator: first-fit slot allocation of cores to jobs, top level.
`timescale 1ns / 1ps

// Hands out core slots to jobs and takes them back. An allocate request
// (tuser = 0) gives the lowest free slots to the job, one result item per slot
// with the slot index and its interleaved physical core, tlast on the final one;
// it is refused (status 2) when the process is not running or the count exceeds
// the free cores, and a count of zero gives one empty success item (status 1).
// A release request (tuser = 1) frees every slot of the tag and returns one
// item (status 3) with the number freed. One slot is examined per cycle by a
// single scan counter, and a release reads the owner tags through the
// registered port of the tag memory. A new request is taken once the previous
// one has finished, even while its last result still waits in the output
// register; result stalls hold the grant scan.
module core_group_allocator #(
   parameter int NUM_CORES = 16,
   parameter int TAG_BITS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [7:0] job_tag, [12:8] core_count, [13] process_running, [15:14] zero
   input  logic [cga_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  logic                         req_tuser,
   // result channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [3:0] slot_index, [7:4] core_number, [12:8] released_count, [15:13] zero
   output logic [cga_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]                   rsp_tuser,
   output logic                         rsp_tlast
);

   import cga_pkg::*;

   localparam int IW   = $clog2(NUM_CORES);
   localparam int UW   = $clog2(NUM_CORES + 1);
   localparam int HALF = NUM_CORES / 2;
   localparam int QUAD = NUM_CORES / 4;
   localparam int XW   = (IW + 1 > SLOT_W) ? IW + 1 : SLOT_W;
   localparam int RW   = (UW > RELEASED_W) ? UW : RELEASED_W;
   localparam int SW   = ((UW > COUNT_W) ? UW : COUNT_W) + 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_CORES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_GRANT,
      S_REL_RD,
      S_REL_TAIL,
      S_SINGLE
   } state_type;

   // interleaved physical core of a slot
   function automatic logic [CORE_W-1:0] core_of(input logic [IW-1:0] i);
      logic [XW-1:0] base;
      logic [XW-1:0] sum;
      logic          odd;
      logic          hi;
      base = XW'(i >> 1);
      odd  = i[0];
      hi   = (XW'(i) >= XW'(HALF));
      if (odd && hi) begin
         sum = base + XW'(2 * QUAD);
      end else if (odd || hi) begin
         sum = base + XW'(QUAD);
      end else begin
         sum = base;
      end
      return sum[CORE_W-1:0];
   endfunction

   state_type              state_ff, state_in;
   logic [NUM_CORES-1:0]   owned_ff, owned_in;
   logic [UW-1:0]          in_use_ff, in_use_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [IW-1:0]          pend_idx_ff, pend_idx_in;
   logic                   pend_ff, pend_in;
   logic [UW-1:0]          freed_ff, freed_in;
   logic [COUNT_W-1:0]     granted_ff, granted_in;
   logic                   cmd_ff, cmd_in;
   logic [TAG_BITS-1:0]    tag_ff, tag_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   running_ff, running_in;
   status_type             single_ff, single_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [CORE_W-1:0]      rsp_core_ff, rsp_core_in;
   logic [RELEASED_W-1:0]  rsp_freed_ff, rsp_freed_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_wr_en;
   logic [TAG_BITS-1:0]    ram_rd_data;
   logic                   out_free;
   logic                   req_take;
   logic [XW-1:0]          slot_wide;
   logic [RW-1:0]          freed_wide;

   cga_owner_ram #(
      .DEPTH (NUM_CORES),
      .WIDTH (TAG_BITS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (tag_ff),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign slot_wide  = XW'(idx_ff);
   assign freed_wide = RW'(freed_ff);

   always_comb begin
      state_in      = state_ff;
      owned_in      = owned_ff;
      in_use_in     = in_use_ff;
      idx_in        = idx_ff;
      pend_idx_in   = pend_idx_ff;
      pend_in       = pend_ff;
      freed_in      = freed_ff;
      granted_in    = granted_ff;
      cmd_in        = cmd_ff;
      tag_in        = tag_ff;
      count_in      = count_ff;
      running_in    = running_ff;
      single_in     = single_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_core_in   = rsp_core_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ram_wr_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in     = req_tuser;
               tag_in     = TAG_BITS'(req_tdata[JOB_TAG_W-1:0]);
               count_in   = req_tdata[JOB_TAG_W +: COUNT_W];
               running_in = req_tdata[JOB_TAG_W + COUNT_W];
               idx_in     = '0;
               pend_in    = 1'b0;
               freed_in   = '0;
               granted_in = '0;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (cmd_ff == CMD_RELEASE) begin
               state_in = S_REL_RD;
            end else if (!running_ff ||
                         (SW'(count_ff) + SW'(in_use_ff) > SW'(NUM_CORES))) begin
               single_in = ST_REFUSE;
               state_in  = S_SINGLE;
            end else if (count_ff == '0) begin
               single_in = ST_EMPTY;
               state_in  = S_SINGLE;
            end else begin
               // the free count equals the owned count's complement, so the
               // scan always finds enough slots once the check above passes
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            if (owned_ff[idx_ff]) begin
               idx_in = idx_ff + 1'b1;
            end else if (out_free) begin
               owned_in[idx_ff] = 1'b1;
               ram_wr_en        = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_status_in    = ST_GRANT;
               rsp_slot_in      = slot_wide[SLOT_W-1:0];
               rsp_core_in      = core_of(idx_ff);
               rsp_freed_in     = '0;
               granted_in       = granted_ff + 1'b1;
               if (granted_ff + 1'b1 == count_ff) begin
                  rsp_last_in = 1'b1;
                  in_use_in   = in_use_ff + UW'(count_ff);
                  state_in    = S_IDLE;
               end else begin
                  rsp_last_in = 1'b0;
                  idx_in      = idx_ff + 1'b1;
               end
            end
         end
         S_REL_RD: begin
            // tag of pend_idx arrives this cycle; idx_ff is read for the next
            if (pend_ff && owned_ff[pend_idx_ff] && ram_rd_data == tag_ff) begin
               owned_in[pend_idx_ff] = 1'b0;
               freed_in              = freed_ff + 1'b1;
            end
            pend_in     = 1'b1;
            pend_idx_in = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = S_REL_TAIL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_REL_TAIL: begin
            if (owned_ff[pend_idx_ff] && ram_rd_data == tag_ff) begin
               owned_in[pend_idx_ff] = 1'b0;
               freed_in              = freed_ff + 1'b1;
            end
            pend_in   = 1'b0;
            single_in = ST_RELEASE;
            state_in  = S_SINGLE;
         end
         S_SINGLE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = single_ff;
               rsp_slot_in   = '0;
               rsp_core_in   = '0;
               rsp_freed_in  = (single_ff == ST_RELEASE) ?
                               freed_wide[RELEASED_W-1:0] : '0;
               rsp_last_in   = 1'b1;
               if (single_ff == ST_RELEASE) begin
                  in_use_in = in_use_ff - freed_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      pend_ff       <= pend_in;
      freed_ff      <= freed_in;
      granted_ff    <= granted_in;
      cmd_ff        <= cmd_in;
      tag_ff        <= tag_in;
      count_ff      <= count_in;
      running_ff    <= running_in;
      single_ff     <= single_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_core_ff   <= rsp_core_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         owned_ff     <= '0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         owned_ff     <= owned_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SLOT_W - CORE_W - RELEASED_W)'(0),
                        rsp_freed_ff, rsp_core_ff, rsp_slot_ff};

`ifndef NO_ASSERTIONS
   // between requests the use count matches the owned slots
   a_use_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (32'(in_use_ff) == 32'($countones(owned_ff))))
      else $error("cores in use differs from owned slot count");

   // a grant is only ever made from a free slot
   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GRANT && ram_wr_en) |-> !owned_ff[idx_ff])
      else $error("grant of a slot already owned");

   // single-item results always close their request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_GRANT) |-> rsp_last_ff)
      else $error("non-grant result without last");

   // the grant scan never runs past the final slot
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GRANT && idx_ff == LAST_IDX) |-> !owned_ff[idx_ff])
      else $error("grant scan reached the end without a free slot");
`endif

endmodule
